// ===== design/tfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared types and constants of the TinyLFU frequency sketch: controller
// states, the command and status groups between controller and datapath,
// the configuration set and the counter arithmetic.
// ----------------------------------------------------------------------------
package tfs_pkg;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_HOT_THRESHOLD  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_DECAY_INTERVAL = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_LOCAL_NODE     = 2'd2;

   localparam logic [3:0]  HOT_THRESHOLD_RST  = 4'd3;
   localparam logic [31:0] DECAY_INTERVAL_RST = 32'd100000;
   localparam logic [1:0]  LOCAL_NODE_RST     = 2'd0;

   localparam logic [3:0] CTR_MAX = 4'd15;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_FLUSH,
      ST_IDLE,
      ST_LOOK,
      ST_DK2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [3:0]  hot_threshold;
      logic [31:0] decay_interval;
      logic [1:0]  local_node;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic ctr_write;
      logic dk_write_a;
      logic dk_write_b;
      logic finish;
      logic sweep_step;
   } cmd_type;

   typedef struct packed {
      logic seen;
      logic rsp_free;
      logic decay_now;
      logic sweep_last;
   } status_type;

   function automatic logic [3:0] ctr_inc(input logic [3:0] value);
      return (value == CTR_MAX) ? value : value + 4'd1;
   endfunction

endpackage

// ===== design/tinylfu_frequency_sketch.sv =====
// ----------------------------------------------------------------------------
// tinylfu_frequency_sketch
// An item is accepted only in the idle state, one item at a time: lookup,
// then a counter write when the doorkeeper has already seen the key or two
// doorkeeper writes on a first sight, then the done state, which loads the
// result into the output register. The single write port of the doorkeeper
// store sets the second write on a first sight, and a result waiting in the
// output register holds back both the next result and the next acceptance.
// After reset and after every access that triggers a decay, a sweep clears
// or halves all counter banks and clears the doorkeeper, one column a cycle;
// no item is accepted during it, while register writes are taken.
// ----------------------------------------------------------------------------
module tinylfu_frequency_sketch import tfs_pkg::*; #(
   parameter int SKETCH_WIDTH = 16384,
   parameter int SKETCH_ROWS  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // key_hash [63:0], node_known [64], home_node [66:65], zero [71:67]
   input  logic [71:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // admitted [0], frequency [4:1], candidate [5], decayed [6], zero [7]
   output logic [7:0]            rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;
   logic       rsp_admitted;
   logic [3:0] rsp_frequency;
   logic       rsp_candidate;
   logic       rsp_decayed;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hot_threshold  <= HOT_THRESHOLD_RST;
         cfg_ff.decay_interval <= DECAY_INTERVAL_RST;
         cfg_ff.local_node     <= LOCAL_NODE_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_HOT_THRESHOLD:  cfg_ff.hot_threshold  <= csr_wdata[3:0];
            REG_DECAY_INTERVAL: cfg_ff.decay_interval <= csr_wdata[31:0];
            REG_LOCAL_NODE:     cfg_ff.local_node     <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   tfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tfs_datapath #(
      .SKETCH_WIDTH (SKETCH_WIDTH),
      .SKETCH_ROWS  (SKETCH_ROWS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_key_hash   (req_tdata[63:0]),
      .req_node_known (req_tdata[64]),
      .req_home_node  (req_tdata[66:65]),
      .cmd            (cmd),
      .status         (status),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_admitted   (rsp_admitted),
      .rsp_frequency  (rsp_frequency),
      .rsp_candidate  (rsp_candidate),
      .rsp_decayed    (rsp_decayed)
   );

   assign rsp_tdata = {1'b0, rsp_decayed, rsp_candidate, rsp_frequency, rsp_admitted};

endmodule

// ===== design/tfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tfs_ctrl
// Sequencer of the frequency sketch: runs the store sweeps, takes one item
// at a time, steps it through lookup, counter or doorkeeper update and result.
// ----------------------------------------------------------------------------
module tfs_ctrl import tfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (status.seen) begin
               cmd.ctr_write = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.dk_write_a = 1'b1;
               state_in       = ST_DK2;
            end
         end
         ST_DK2: begin
            cmd.dk_write_b = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = status.decay_now ? ST_SWEEP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/tfs_datapath.sv =====
// ----------------------------------------------------------------------------
// tfs_datapath
// Counter banks, doorkeeper store, access counter and result register of the
// frequency sketch, driven by the commands of the sequencer.
// ----------------------------------------------------------------------------
module tfs_datapath import tfs_pkg::*; #(
   parameter int SKETCH_WIDTH = 16384,
   parameter int SKETCH_ROWS  = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic [63:0] req_key_hash,
   input  logic        req_node_known,
   input  logic [1:0]  req_home_node,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic        rsp_admitted,
   output logic [3:0]  rsp_frequency,
   output logic        rsp_candidate,
   output logic        rsp_decayed
);

   localparam int ColW   = $clog2(SKETCH_WIDTH);
   localparam int DkSize = SKETCH_ROWS * SKETCH_WIDTH;
   localparam int DkW    = $clog2(DkSize);
   localparam int LaneW  = (SKETCH_ROWS > 1) ? $clog2(SKETCH_ROWS) : 1;
   localparam logic [DkW-1:0] DkMask = DkW'(DkSize - 1);

   logic [SKETCH_ROWS-1:0] dk_mem [SKETCH_WIDTH];

   logic [ColW-1:0]        col_in    [SKETCH_ROWS];
   logic [ColW-1:0]        col_ff    [SKETCH_ROWS];
   logic [3:0]             ctr_rd_ff [SKETCH_ROWS];
   logic [3:0]             ctr_new_ff[SKETCH_ROWS];
   logic [DkW-1:0]         idx_a;
   logic [DkW-1:0]         idx_b;
   logic [ColW-1:0]        word_a_ff;
   logic [ColW-1:0]        word_b_ff;
   logic [LaneW-1:0]       lane_a_ff;
   logic [LaneW-1:0]       lane_b_ff;
   logic [SKETCH_ROWS-1:0] dk_rd_a_ff;
   logic [SKETCH_ROWS-1:0] dk_rd_b_ff;
   logic [SKETCH_ROWS-1:0] bit_a;
   logic [SKETCH_ROWS-1:0] bit_b;
   logic                   same_word;
   logic [SKETCH_ROWS-1:0] dk_new_a;
   logic [SKETCH_ROWS-1:0] dk_new_b;
   logic                   node_known_ff;
   logic [1:0]             home_node_ff;
   logic                   adm_ff;
   logic [ColW-1:0]        sweep_idx_ff;
   logic                   sweep_clr_ff;
   logic                   wr_pend_ff;
   logic [ColW-1:0]        wr_addr_ff;
   logic [31:0]            count_ff;
   logic [31:0]            count_plus;
   logic [3:0]             min_v;
   logic [3:0]             freq;
   logic                   cand;
   logic                   rsp_valid_ff;
   logic                   rsp_adm_ff;
   logic [3:0]             rsp_freq_ff;
   logic                   rsp_cand_ff;
   logic                   rsp_dec_ff;

   assign idx_a = req_key_hash[DkW-1:0] & DkMask;
   assign idx_b = req_key_hash[32 +: DkW] & DkMask;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         word_a_ff     <= idx_a[ColW-1:0];
         word_b_ff     <= idx_b[ColW-1:0];
         lane_a_ff     <= LaneW'(idx_a >> ColW);
         lane_b_ff     <= LaneW'(idx_b >> ColW);
         dk_rd_a_ff    <= dk_mem[idx_a[ColW-1:0]];
         dk_rd_b_ff    <= dk_mem[idx_b[ColW-1:0]];
         node_known_ff <= req_node_known;
         home_node_ff  <= req_home_node;
      end
   end

   assign bit_a     = SKETCH_ROWS'(1) << lane_a_ff;
   assign bit_b     = SKETCH_ROWS'(1) << lane_b_ff;
   assign same_word = (word_a_ff == word_b_ff);
   assign dk_new_a  = dk_rd_a_ff | bit_a | (same_word ? bit_b : '0);
   assign dk_new_b  = dk_rd_b_ff | bit_b | (same_word ? bit_a : '0);

   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         dk_mem[wr_addr_ff] <= '0;
      end else if (cmd.dk_write_a) begin
         dk_mem[word_a_ff] <= dk_new_a;
      end else if (cmd.dk_write_b) begin
         dk_mem[word_b_ff] <= dk_new_b;
      end
   end

   for (genvar r = 0; r < SKETCH_ROWS; r++) begin : g_row
      logic [3:0]      ctr_mem [SKETCH_WIDTH];
      logic [ColW-1:0] rd_addr;

      assign col_in[r] = req_key_hash[16*r +: ColW];
      assign rd_addr   = cmd.capture ? col_in[r] : sweep_idx_ff;

      always_ff @(posedge clock) begin
         if (cmd.capture || cmd.sweep_step) begin
            ctr_rd_ff[r] <= ctr_mem[rd_addr];
         end
         if (cmd.capture) begin
            col_ff[r] <= col_in[r];
         end
         if (cmd.ctr_write) begin
            ctr_new_ff[r] <= ctr_inc(ctr_rd_ff[r]);
         end
      end

      always_ff @(posedge clock) begin
         if (wr_pend_ff) begin
            ctr_mem[wr_addr_ff] <= sweep_clr_ff ? 4'd0 : (ctr_rd_ff[r] >> 1);
         end else if (cmd.ctr_write) begin
            ctr_mem[col_ff[r]] <= ctr_inc(ctr_rd_ff[r]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_idx_ff <= '0;
         sweep_clr_ff <= 1'b1;
         wr_pend_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         adm_ff       <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.sweep_step;
         if (cmd.sweep_step) begin
            sweep_idx_ff <= sweep_idx_ff + ColW'(1);
         end
         if (cmd.capture) begin
            sweep_clr_ff <= 1'b0;
         end
         if (cmd.ctr_write) begin
            adm_ff <= 1'b1;
         end else if (cmd.dk_write_a) begin
            adm_ff <= 1'b0;
         end
         if (cmd.finish) begin
            count_ff     <= status.decay_now ? '0 : count_plus;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_step) begin
         wr_addr_ff <= sweep_idx_ff;
      end
      if (cmd.finish) begin
         rsp_adm_ff  <= adm_ff;
         rsp_freq_ff <= freq;
         rsp_cand_ff <= cand;
         rsp_dec_ff  <= status.decay_now;
      end
   end

   always_comb begin
      min_v = CTR_MAX;
      for (int i = 0; i < SKETCH_ROWS; i++) begin
         if (ctr_new_ff[i] < min_v) begin
            min_v = ctr_new_ff[i];
         end
      end
      if (!adm_ff) begin
         freq = 4'd0;
      end else begin
         freq = ctr_inc(min_v);
      end
      cand = adm_ff && (freq >= cfg.hot_threshold) && node_known_ff
             && (home_node_ff != cfg.local_node);
   end

   assign count_plus = count_ff + 32'd1;

   assign status.seen       = dk_rd_a_ff[lane_a_ff] & dk_rd_b_ff[lane_b_ff];
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;
   assign status.decay_now  = (count_plus >= cfg.decay_interval);
   assign status.sweep_last = (sweep_idx_ff == ColW'(SKETCH_WIDTH - 1));

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_admitted  = rsp_adm_ff;
   assign rsp_frequency = rsp_freq_ff;
   assign rsp_candidate = rsp_cand_ff;
   assign rsp_decayed   = rsp_dec_ff;

   a_ctr_only_when_seen: assert property (@(posedge clock) disable iff (reset)
      cmd.ctr_write |-> status.seen)
      else $error("Counters were bumped for a key the doorkeeper had not seen.");

   a_sweep_write_alone: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> !(cmd.ctr_write || cmd.dk_write_a || cmd.dk_write_b))
      else $error("A sweep write collided with an item write.");

   a_decay_restarts_count: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && status.decay_now |=> count_ff == '0)
      else $error("The access count did not restart after a decay.");

   a_candidate_admitted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_cand_ff |-> rsp_adm_ff && (rsp_freq_ff != 4'd0))
      else $error("A candidate was flagged without an admitted frequency.");

endmodule

// ===== dv/tb_tinylfu_frequency_sketch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tinylfu_frequency_sketch
// Self-checking bench for the frequency sketch. A short table of directed
// accesses and register writes comes first. Random phases follow: each phase
// uses its own register settings and idling pattern, and draws keys mostly
// from a small pool so that counters climb to saturation. Every result item
// is compared with the outcome given by its table row, if any, or else with
// a behavioural copy of the sketch, doorkeeper and decay counter in the bench.
// ----------------------------------------------------------------------------
module tb_tinylfu_frequency_sketch;
   import tfs_pkg::*;

   localparam int     HALF_PERIOD  = 5;
   localparam int     RESET_CYCLES = 9;
   localparam int     COUNTER_ROWS = 4;
   localparam int     COLUMN_BITS  = 14;
   localparam int     STORE_DEPTH  = 65536;
   localparam int     POOL_SIZE    = 12;
   localparam int     HOLD_CYCLES  = 400;
   localparam int     DRAIN_CYCLES = 40;
   localparam longint CYCLE_LIMIT  = 1000000;

   localparam logic [CSR_ADDR_W-1:0] REG_SPARE = 2'd3;

   localparam logic [63:0] KEY_ZERO = 64'h0000_0000_0000_0000;
   localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] KEY_HALF = 64'h0000_5555_0000_0000;

   typedef struct packed {
      logic [1:0]  home_node;
      logic        node_known;
      logic [63:0] key_hash;
   } access_type;

   typedef struct packed {
      logic       decayed;
      logic       candidate;
      logic [3:0] frequency;
      logic       admitted;
   } outcome_type;

   typedef enum logic {ROW_ACCESS, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      access_type                acc;
      logic [CSR_ADDR_W-1:0]     reg_idx;
      logic [CSR_DATA_W-1:0]     value;
      bit                        typed;
      outcome_type               want;
   } stim_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [71:0]           req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   logic [3:0]  sketch_mem [STORE_DEPTH];
   bit          dk_mem     [STORE_DEPTH];
   logic [31:0] access_ctr;
   cfg_type     shadow_cfg;

   outcome_type pending_outcomes [$];
   int       failures       = 0;
   int       send_idle_pct  = 0;
   int       recv_stall_pct = 0;
   int       hold_requests  = 0;
   int       hold_served    = 0;
   int       hold_left      = 0;
   longint   cycle_count    = 0;

   tinylfu_frequency_sketch dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic estimate_frequency(input access_type a, output outcome_type o);
      logic [15:0] pos_a;
      logic [15:0] pos_b;
      logic [15:0] idx;
      logic [3:0]  least;
      o = '0;
      pos_a = a.key_hash[15:0];
      pos_b = a.key_hash[47:32];
      if (!(dk_mem[pos_a] && dk_mem[pos_b])) begin
         dk_mem[pos_a] = 1'b1;
         dk_mem[pos_b] = 1'b1;
      end else begin
         o.admitted = 1'b1;
         least = CTR_MAX;
         for (int r = 0; r < COUNTER_ROWS; r++) begin
            idx = {r[1:0], a.key_hash[16*r +: COLUMN_BITS]};
            if (sketch_mem[idx] != CTR_MAX) sketch_mem[idx] = sketch_mem[idx] + 4'd1;
         end
         for (int r = 0; r < COUNTER_ROWS; r++) begin
            idx = {r[1:0], a.key_hash[16*r +: COLUMN_BITS]};
            if (sketch_mem[idx] < least) least = sketch_mem[idx];
         end
         o.frequency = (least < CTR_MAX) ? least + 4'd1 : CTR_MAX;
         o.candidate = (o.frequency >= shadow_cfg.hot_threshold) && a.node_known
                       && (a.home_node != shadow_cfg.local_node);
      end
      access_ctr = access_ctr + 32'd1;
      if (access_ctr >= shadow_cfg.decay_interval) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            sketch_mem[i] = sketch_mem[i] >> 1;
            dk_mem[i] = 1'b0;
         end
         access_ctr = '0;
         o.decayed = 1'b1;
      end
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[6:0];
         if (pending_outcomes.size() == 0) begin
            $error("result item with no access outstanding: %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("admitted", want.admitted, got.admitted);
            check_field("frequency", want.frequency, got.frequency);
            check_field("candidate", want.candidate, got.candidate);
            check_field("decayed", want.decayed, got.decayed);
         end
      end
   end

   // The long hold-off is counted here, so the sender keeps offering items.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_access(input access_type a, input bit typed, input outcome_type want);
      outcome_type predicted;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      estimate_frequency(a, predicted);
      pending_outcomes.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         REG_HOT_THRESHOLD:  shadow_cfg.hot_threshold  = value[3:0];
         REG_DECAY_INTERVAL: shadow_cfg.decay_interval = value;
         REG_LOCAL_NODE:     shadow_cfg.local_node     = value[1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic stim_row_type access_row(input logic [63:0] h, input logic k,
                                               input logic [1:0] n);
      stim_row_type r;
      r.kind           = ROW_ACCESS;
      r.acc.key_hash   = h;
      r.acc.node_known = k;
      r.acc.home_node  = n;
      r.reg_idx        = '0;
      r.value          = '0;
      r.typed          = 1'b0;
      r.want           = '0;
      return r;
   endfunction

   function automatic stim_row_type typed_row(input logic [63:0] h, input logic k,
                                              input logic [1:0] n, input logic adm,
                                              input logic [3:0] freq, input logic cand,
                                              input logic dec);
      stim_row_type r;
      r = access_row(h, k, n);
      r.typed = 1'b1;
      r.want  = {dec, cand, freq, adm};
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_ADDR_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] value);
      stim_row_type r;
      r = access_row(KEY_ZERO, 1'b0, 2'd0);
      r.kind    = ROW_CSR;
      r.reg_idx = idx;
      r.value   = value;
      return r;
   endfunction

   task automatic run_phase(input logic [3:0] thr, input logic [31:0] decay_len,
                            input logic [1:0] home_local, input int send_pct,
                            input int recv_pct, input int count, input bit hold);
      logic [63:0] pool [POOL_SIZE];
      access_type  a;
      int          pick;
      settle();
      write_reg(REG_HOT_THRESHOLD, {28'd0, thr});
      write_reg(REG_DECAY_INTERVAL, decay_len);
      write_reg(REG_LOCAL_NODE, {30'd0, home_local});
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      foreach (pool[i]) pool[i] = {$urandom(), $urandom()};
      if (hold) hold_requests++;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            a.key_hash = pool[$urandom_range(POOL_SIZE-1)];
         end else if (pick < 90) begin
            // Shares one doorkeeper position with a pooled key.
            a.key_hash = {$urandom(), pool[$urandom_range(POOL_SIZE-1)][31:0]};
         end else begin
            a.key_hash = {$urandom(), $urandom()};
         end
         a.node_known = 1'($urandom_range(1));
         a.home_node  = 2'($urandom_range(3));
         send_access(a, 1'b0, '0);
      end
   endtask

   initial begin
      stim_row_type directed [$];
      for (int i = 0; i < STORE_DEPTH; i++) begin
         sketch_mem[i] = '0;
         dk_mem[i] = 1'b0;
      end
      access_ctr                = '0;
      shadow_cfg.hot_threshold  = HOT_THRESHOLD_RST;
      shadow_cfg.decay_interval = DECAY_INTERVAL_RST;
      shadow_cfg.local_node     = LOCAL_NODE_RST;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      directed.push_back(typed_row(KEY_ZERO, 1'b0, 2'd0, 1'b0, 4'd0, 1'b0, 1'b0));
      directed.push_back(typed_row(KEY_ZERO, 1'b1, 2'd1, 1'b1, 4'd2, 1'b0, 1'b0));
      directed.push_back(typed_row(KEY_ZERO, 1'b1, 2'd1, 1'b1, 4'd3, 1'b1, 1'b0));
      directed.push_back(typed_row(KEY_ZERO, 1'b1, 2'd0, 1'b1, 4'd4, 1'b0, 1'b0));
      directed.push_back(typed_row(KEY_ZERO, 1'b0, 2'd3, 1'b1, 4'd5, 1'b0, 1'b0));
      directed.push_back(typed_row(KEY_ONES, 1'b1, 2'd3, 1'b0, 4'd0, 1'b0, 1'b0));
      directed.push_back(typed_row(KEY_ONES, 1'b1, 2'd3, 1'b1, 4'd2, 1'b0, 1'b0));
      directed.push_back(csr_row(REG_HOT_THRESHOLD, 32'd0));
      directed.push_back(typed_row(KEY_ZERO, 1'b1, 2'd2, 1'b1, 4'd6, 1'b1, 1'b0));
      directed.push_back(typed_row(KEY_ZERO, 1'b0, 2'd2, 1'b1, 4'd7, 1'b0, 1'b0));
      directed.push_back(csr_row(REG_SPARE, 32'hFFFF_FFFF));
      directed.push_back(access_row(KEY_ZERO, 1'b1, 2'd0));
      directed.push_back(csr_row(REG_HOT_THRESHOLD, 32'd15));
      repeat (9) directed.push_back(access_row(KEY_ZERO, 1'b1, 2'd1));
      directed.push_back(typed_row(KEY_HALF, 1'b1, 2'd3, 1'b0, 4'd0, 1'b0, 1'b0));
      directed.push_back(access_row(KEY_HALF, 1'b1, 2'd3));
      directed.push_back(csr_row(REG_DECAY_INTERVAL, 32'd0));
      directed.push_back(access_row(KEY_ZERO, 1'b1, 2'd1));
      directed.push_back(typed_row(KEY_ZERO, 1'b1, 2'd1, 1'b0, 4'd0, 1'b0, 1'b1));

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            settle();
            write_reg(directed[i].reg_idx, directed[i].value);
         end else begin
            send_access(directed[i].acc, directed[i].typed, directed[i].want);
         end
      end

      run_phase(4'd3, 32'd1000, 2'd0, 0, 0, 300, 1'b0);
      run_phase(4'd15, 32'd1000, 2'd3, 78, 0, 300, 1'b0);
      run_phase(4'd1, 32'hFFFF_FFFF, 2'd1, 0, 78, 200, 1'b1);
      run_phase(4'd7, 32'd1000, 2'd2, 31, 31, 250, 1'b0);
      run_phase(4'($urandom_range(15, 1)), $urandom_range(1200, 1000),
                2'($urandom_range(3)), 0, 0, 200, 1'b0);

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/tfs_pkg.sv
design/tfs_ctrl.sv
design/tfs_datapath.sv
design/tinylfu_frequency_sketch.sv
dv/tb_tinylfu_frequency_sketch.sv
